@@ rtl/crd_pkg.sv @@
// Shared types, widths and helpers of the camera ray direction block.
package crd_pkg;

  localparam int COMP_W    = 21;
  localparam int CFG_W     = 3 * COMP_W;
  localparam int CFG_IDX_W = 2;
  localparam int UV_W      = 17;
  localparam int OUT_W     = 16;
  localparam int OUT_FRAC  = 14;
  localparam int OUT_ONE   = 1 << OUT_FRAC;
  localparam int NORM_W    = 30;
  localparam int RAD_W     = 2 * NORM_W + 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int Q_W       = OUT_FRAC + 1;
  localparam int SQRT_PER  = 4;
  localparam int DIV_PER   = 4;

  localparam int DEF_UV_FRAC_BITS = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER = 2'd0,
    REG_HSPAN  = 2'd1,
    REG_VSPAN  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [UV_W-1:0] screen_u;
    logic [UV_W-1:0] screen_v;
  } ray_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    logic                    degenerate;
  } ray_out_t;

  // Normalized magnitudes with their signs, carried beside the length math.
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   degen;
  } norm_t;

  function automatic logic signed [COMP_W-1:0] comp_of(logic [CFG_W-1:0] r, int idx);
    comp_of = r[idx*COMP_W +: COMP_W];
  endfunction

endpackage

@@ rtl/crd_sqrt.sv @@
// Pipelined integer square root with a sideband word carried alongside.
module crd_sqrt
  import crd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [RAD_W-1:0]  rad_i,
  input  norm_t             side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [ROOT_W-1:0] root_o,
  output norm_t             side_o
);

  localparam int STEPS = ROOT_W;
  localparam int NST   = (STEPS + SQRT_PER - 1) / SQRT_PER;
  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_s  [NST+1];
  logic [ROOT_W-1:0] root_s [NST+1];
  logic [RAD_W-1:0]  rad_s  [NST+1];
  norm_t             side_s [NST+1];
  logic [NST:0]      v_s;
  logic [NST+1:1]    rdy;

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign side_s[0] = side_i;
  assign v_s[0]    = valid_i;
  assign rdy[NST+1] = ready_i;
  assign ready_o   = rdy[1];
  assign valid_o   = v_s[NST];
  assign root_o    = root_s[NST];
  assign side_o    = side_s[NST];

  for (genvar k = 1; k <= NST; k++) begin : g_stage
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;
    logic [RAD_W-1:0]  rad_d;

    assign rdy[k] = !v_s[k] || rdy[k+1];

    always_comb begin
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] trial;
      rem_d  = rem_s[k-1];
      root_d = root_s[k-1];
      rad_d  = rad_s[k-1];
      for (int j = 0; j < SQRT_PER; j++) begin
        if ((k - 1) * SQRT_PER + j < STEPS) begin
          sh    = {rem_d[REM_W-3:0], rad_d[RAD_W-1:RAD_W-2]};
          trial = REM_W'({root_d, 2'b01});
          rad_d = {rad_d[RAD_W-3:0], 2'b00};
          if (sh >= trial) begin
            rem_d  = sh - trial;
            root_d = {root_d[ROOT_W-2:0], 1'b1};
          end else begin
            rem_d  = sh;
            root_d = {root_d[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_s[k-1]) begin
        rem_s[k]  <= rem_d;
        root_s[k] <= root_d;
        rad_s[k]  <= rad_d;
        side_s[k] <= side_s[k-1];
      end
    end
  end

endmodule

@@ rtl/crd_div.sv @@
// Pipelined rounded division of three magnitudes by the vector length.
module crd_div
  import crd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [ROOT_W-1:0]   len_i,
  input  norm_t               side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [2:0][Q_W-1:0] quot_o,
  output norm_t               side_o
);

  localparam int STEPS = Q_W;
  localparam int NST   = 1 + (STEPS + DIV_PER - 1) / DIV_PER;
  localparam int REM_W = ROOT_W + 1;
  localparam int NUM_W = NORM_W + OUT_FRAC + 1;

  logic [2:0][REM_W-1:0] rem_s  [NST+1];
  logic [2:0][Q_W-1:0]   low_s  [NST+1];
  logic [2:0][Q_W-1:0]   quot_s [NST+1];
  logic [ROOT_W-1:0]     len_s  [NST+1];
  norm_t                 side_s [NST+1];
  logic [NST:0]          v_s;
  logic [NST+1:1]        rdy;

  assign rem_s[0]   = '0;
  assign low_s[0]   = '0;
  assign quot_s[0]  = '0;
  assign len_s[0]   = len_i;
  assign side_s[0]  = side_i;
  assign v_s[0]     = valid_i;
  assign rdy[NST+1] = ready_i;
  assign ready_o    = rdy[1];
  assign valid_o    = v_s[NST];
  assign quot_o     = quot_s[NST];
  assign side_o     = side_s[NST];

  for (genvar k = 1; k <= NST; k++) begin : g_stage
    logic [2:0][REM_W-1:0] rem_d;
    logic [2:0][Q_W-1:0]   low_d;
    logic [2:0][Q_W-1:0]   quot_d;

    assign rdy[k] = !v_s[k] || rdy[k+1];

    if (k == 1) begin : g_prep
      // The quotient stays below 2^Q_W, so the top of the numerator already
      // sits below the divisor and only Q_W quotient bits remain.
      always_comb begin
        logic [NUM_W-1:0] num;
        for (int i = 0; i < 3; i++) begin
          num = {side_s[0].mag[i], OUT_FRAC'(0)} + NUM_W'(len_s[0] >> 1);
          rem_d[i]  = REM_W'(num >> Q_W);
          low_d[i]  = num[Q_W-1:0];
          quot_d[i] = '0;
        end
      end
    end else begin : g_step
      always_comb begin
        logic [REM_W-1:0] sh;
        rem_d  = rem_s[k-1];
        low_d  = low_s[k-1];
        quot_d = quot_s[k-1];
        for (int j = 0; j < DIV_PER; j++) begin
          if ((k - 2) * DIV_PER + j < STEPS) begin
            for (int i = 0; i < 3; i++) begin
              sh       = {rem_d[i][REM_W-2:0], low_d[i][Q_W-1]};
              low_d[i] = {low_d[i][Q_W-2:0], 1'b0};
              if (sh >= REM_W'(len_s[k-1])) begin
                rem_d[i]  = sh - REM_W'(len_s[k-1]);
                quot_d[i] = {quot_d[i][Q_W-2:0], 1'b1};
              end else begin
                rem_d[i]  = sh;
                quot_d[i] = {quot_d[i][Q_W-2:0], 1'b0};
              end
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_s[k] <= v_s[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_s[k-1]) begin
        rem_s[k]  <= rem_d;
        low_s[k]  <= low_d;
        quot_s[k] <= quot_d;
        len_s[k]  <= len_s[k-1];
        side_s[k] <= side_s[k-1];
      end
    end
  end

endmodule

@@ rtl/camera_ray_direction.sv @@
// Top level of the pinhole camera primary ray direction pipeline.
//
// Software writes the three span registers (corner offset, horizontal and
// vertical span) through the write port while no word is in flight. Each
// input word carries a screen position (u, v); each output word carries the
// unit direction of corner + u*horizontal + v*vertical in Q1.14, or a zero
// vector with the degenerate flag when that sum is exactly zero.
// Both channels use valid/ready. One word is accepted per clock and one
// result leaves per clock when the receiver keeps ready high.
// A word passes 21 register stages: seven front stages (products, sum,
// maximum, leading one, shift, squares, sum of squares), eight square root
// stages at up to four root bits each, a divider set-up stage, four divider
// stages at up to four quotient bits each, and the output register.
// Every stage has its own valid bit and the ready chain lets bubbles fill,
// so a stalled receiver holds the results in place and input is taken until
// the pipeline is full. Reset clears the valid bits and the span registers.
module camera_ray_direction
  import crd_pkg::*;
#(
  parameter int UV_FRAC_BITS = DEF_UV_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ray_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ray_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int UV_TERM_W = (UV_FRAC_BITS + 1 > UV_W + 1) ? UV_FRAC_BITS + 1 : UV_W + 1;
  localparam int D_W       = COMP_W + UV_TERM_W + 2;
  localparam int MAG_W     = D_W - 1;
  localparam int P_W       = $clog2(MAG_W);
  localparam int PROD_W    = COMP_W + UV_W + 1;
  localparam int SQ_W      = 2 * NORM_W;

  logic [CFG_W-1:0] corner_q, hspan_q, vspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      hspan_q  <= '0;
      vspan_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CORNER: corner_q <= cfg_data_i;
        REG_HSPAN:  hspan_q  <= cfg_data_i;
        REG_VSPAN:  vspan_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front stage valid bits and ready chain; stage 8 is the square root unit.
  logic [7:1] fv_q;
  logic [8:1] frdy;
  logic       sq_ready;

  assign frdy[8]    = sq_ready;
  assign in_ready_o = frdy[1];
  for (genvar k = 1; k <= 7; k++) begin : g_rdy
    assign frdy[k] = !fv_q[k] || frdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else begin
      if (frdy[1]) fv_q[1] <= in_valid_i;
      for (int k = 2; k <= 7; k++) begin
        if (frdy[k]) fv_q[k] <= fv_q[k-1];
      end
    end
  end

  // Stage 1: the three terms of each component.
  logic signed [2:0][D_W-1:0] cterm_q, hprod_q, vprod_q;
  always_ff @(posedge clk_i) begin
    if (frdy[1] && in_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        cterm_q[i] <= D_W'(comp_of(corner_q, i)) <<< UV_FRAC_BITS;
        hprod_q[i] <= D_W'(PROD_W'(comp_of(hspan_q, i))
                           * PROD_W'($signed({1'b0, in_data_i.screen_u})));
        vprod_q[i] <= D_W'(PROD_W'(comp_of(vspan_q, i))
                           * PROD_W'($signed({1'b0, in_data_i.screen_v})));
      end
    end
  end

  // Stage 2: sum, sign and magnitude.
  logic [2:0][MAG_W-1:0] mag2_q;
  logic [2:0]            neg2_q;
  always_ff @(posedge clk_i) begin
    if (frdy[2] && fv_q[1]) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [D_W-1:0] d;
        d = cterm_q[i] + hprod_q[i] + vprod_q[i];
        neg2_q[i] <= d[D_W-1];
        mag2_q[i] <= d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);
      end
    end
  end

  // Stage 3: largest magnitude.
  logic [2:0][MAG_W-1:0] mag3_q;
  logic [2:0]            neg3_q;
  logic [MAG_W-1:0]      max3_q;
  always_ff @(posedge clk_i) begin
    if (frdy[3] && fv_q[2]) begin
      logic [MAG_W-1:0] m;
      m = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
      max3_q <= (mag2_q[2] > m) ? mag2_q[2] : m;
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
    end
  end

  // Stage 4: position of the leading one of the largest magnitude.
  logic [2:0][MAG_W-1:0] mag4_q;
  logic [2:0]            neg4_q;
  logic [P_W-1:0]        lead4_q;
  logic                  degen4_q;
  always_ff @(posedge clk_i) begin
    if (frdy[4] && fv_q[3]) begin
      logic [P_W-1:0] p;
      p = '0;
      for (int b = 0; b < MAG_W; b++) begin
        if (max3_q[b]) p = P_W'(b);
      end
      lead4_q  <= p;
      degen4_q <= (max3_q == '0);
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
    end
  end

  // Stage 5: common shift that puts the largest magnitude in [2^29, 2^30).
  norm_t n5_q;
  always_ff @(posedge clk_i) begin
    if (frdy[5] && fv_q[4]) begin
      for (int i = 0; i < 3; i++) begin
        if (lead4_q >= P_W'(NORM_W - 1)) begin
          n5_q.mag[i] <= NORM_W'(mag4_q[i] >> (lead4_q - P_W'(NORM_W - 1)));
        end else begin
          n5_q.mag[i] <= NORM_W'(mag4_q[i] << (P_W'(NORM_W - 1) - lead4_q));
        end
      end
      n5_q.neg   <= neg4_q;
      n5_q.degen <= degen4_q;
    end
  end

  // Stage 6: squares.
  logic [2:0][SQ_W-1:0] sq6_q;
  norm_t                n6_q;
  always_ff @(posedge clk_i) begin
    if (frdy[6] && fv_q[5]) begin
      for (int i = 0; i < 3; i++) begin
        sq6_q[i] <= n5_q.mag[i] * n5_q.mag[i];
      end
      n6_q <= n5_q;
    end
  end

  // Stage 7: sum of squares.
  logic [RAD_W-1:0] rad7_q;
  norm_t            n7_q;
  always_ff @(posedge clk_i) begin
    if (frdy[7] && fv_q[6]) begin
      rad7_q <= RAD_W'(sq6_q[0]) + RAD_W'(sq6_q[1]) + RAD_W'(sq6_q[2]);
      n7_q   <= n6_q;
    end
  end

  logic              sq_valid, dv_ready;
  logic [ROOT_W-1:0] len;
  norm_t             sq_side;

  crd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q[7]),
    .ready_o (sq_ready),
    .rad_i   (rad7_q),
    .side_i  (n7_q),
    .valid_o (sq_valid),
    .ready_i (dv_ready),
    .root_o  (len),
    .side_o  (sq_side)
  );

  logic                dv_valid, out_rdy;
  logic [2:0][Q_W-1:0] quot;
  norm_t               dv_side;

  crd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (dv_ready),
    .len_i   (len),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .ready_i (out_rdy),
    .quot_o  (quot),
    .side_o  (dv_side)
  );

  // Output register: sign, clamp and the zero-vector case.
  logic     out_v_q;
  ray_out_t out_q;
  logic [2:0][OUT_W-1:0] dir_d;

  assign out_rdy     = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [Q_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = (quot[i] > Q_W'(OUT_ONE)) ? Q_W'(OUT_ONE) : quot[i];
      if (dv_side.degen) begin
        dir_d[i] = '0;
      end else if (dv_side.neg[i]) begin
        dir_d[i] = -OUT_W'(q);
      end else begin
        dir_d[i] = OUT_W'(q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv_valid) begin
      out_q.dir_x      <= dir_d[0];
      out_q.dir_y      <= dir_d[1];
      out_q.dir_z      <= dir_d[2];
      out_q.degenerate <= dv_side.degen;
    end
  end

endmodule

@@ sim/tb_camera_ray_direction.sv @@
// Self-checking testbench of the camera ray direction pipeline.
module tb_camera_ray_direction;
  import crd_pkg::*;

  localparam int UVF       = 16;
  localparam int LATENCY   = 21;
  localparam int N_RANDOM  = 1800;
  localparam int CYC_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  ray_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ray_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_CORNER;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Host copy of the span registers.
  logic [CFG_W-1:0] span_reg [3];

  ray_out_t dir_queue [$];
  int       err_cnt = 0;
  int       cycle = 0;
  int       stall_left = 0;

  typedef struct {
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
    bit              known;
    ray_out_t        want;
  } row_t;

  always #5 clk = ~clk;

  camera_ray_direction u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s   = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_out_t unit_direction(logic [UV_W-1:0] u, logic [UV_W-1:0] v);
    ray_out_t    r;
    longint      d;
    logic [63:0] mag [3];
    bit          neg [3];
    logic [63:0] mx;
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] q;
    logic [15:0] o [3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'($signed(span_reg[REG_CORNER][i*COMP_W +: COMP_W])) * (longint'(1) << UVF)
        + longint'($signed(span_reg[REG_HSPAN][i*COMP_W +: COMP_W])) * longint'(u)
        + longint'($signed(span_reg[REG_VSPAN][i*COMP_W +: COMP_W])) * longint'(v);
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      if (mag[i] > mx) mx = mag[i];
    end
    r = '0;
    if (mx == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    s   = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * OUT_ONE + (len >> 1)) / len;
      if (q > OUT_ONE) q = OUT_ONE;
      o[i] = neg[i] ? 16'(-q) : 16'(q);
    end
    r.dir_x = o[0];
    r.dir_y = o[1];
    r.dir_z = o[2];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic write_span(cfg_reg_e idx, logic [63:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[CFG_W-1:0];
    span_reg[idx] = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Out-of-range index must leave all registers untouched.
  task automatic write_bad_index(logic [63:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= 2'd3;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Valid stays high across back-to-back words; it drops only for a gap.
  task automatic send_word(logic [UV_W-1:0] u, logic [UV_W-1:0] v, bit known, ray_out_t want);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data.screen_u <= u;
    in_data.screen_v <= v;
    dir_queue.push_back(known ? want : unit_direction(u, v));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (dir_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [20:0] rand_comp();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 21'h100000;
    if (p == 1) return 21'h0FFFFF;
    if (p < 5) return 21'($urandom_range(0, 4095)) - 21'd2048;
    return 21'($urandom);
  endfunction

  function automatic logic [63:0] rand_span();
    return {1'($urandom), rand_comp(), rand_comp(), rand_comp()};
  endfunction

  function automatic logic [UV_W-1:0] rand_uv();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 17'($urandom_range(0, 1) << UVF);
    if (p == 1) return 17'($urandom);
    return 17'($urandom_range(0, 1 << UVF));
  endfunction

  // Receiver with stalls of random length; compares against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready  <= 1'b0;
        stall_left <= gap_len();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYC_LIMIT) begin
      $display("[camera_ray_direction] ERROR");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (dir_queue.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected word %h", out_data);
      end else begin
        ray_out_t w;
        w = dir_queue.pop_front();
        if (out_data !== w) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp x=%0d y=%0d z=%0d g=%b got x=%0d y=%0d z=%0d g=%b",
                     w.dir_x, w.dir_y, w.dir_z, w.degenerate,
                     out_data.dir_x, out_data.dir_y, out_data.dir_z, out_data.degenerate);
        end
      end
    end
  end

  row_t rows [$];

  initial begin
    ray_out_t zero_dir;
    ray_out_t none;
    row_t     r;
    for (int i = 0; i < 3; i++) span_reg[i] = '0;
    zero_dir = '0;
    zero_dir.degenerate = 1'b1;
    none = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset every span is zero, so each direction is degenerate.
    send_word(17'd0, 17'd0, 1'b1, zero_dir);
    send_word(17'h1FFFF, 17'h1FFFF, 1'b1, zero_dir);
    wait_idle();

    // Camera looking down -z: corner (-2,-1,-1), spans (4,0,0) and (0,2,0).
    write_span(REG_CORNER, {21'h1FFC00, 21'h1FFC00, 21'h1FF800});
    write_span(REG_HSPAN, {1'b1, 21'd0, 21'd0, 21'd4096});
    write_span(REG_VSPAN, {21'd0, 21'd2048, 21'd0});
    write_bad_index('1);
    rows = '{};
    // Screen center looks straight ahead.
    r = '{u: 17'd32768, v: 17'd32768, known: 1'b1,
          want: '{dir_x: 16'sd0, dir_y: 16'sd0, dir_z: -16'sd16384, degenerate: 1'b0}};
    rows.push_back(r);
    rows.push_back('{17'd0, 17'd0, 1'b0, none});
    rows.push_back('{17'd65536, 17'd0, 1'b0, none});
    rows.push_back('{17'd0, 17'd65536, 1'b0, none});
    rows.push_back('{17'd65536, 17'd65536, 1'b0, none});
    rows.push_back('{17'h1FFFF, 17'h1FFFF, 1'b0, none});
    rows.push_back('{17'h1FFFF, 17'd0, 1'b0, none});
    rows.push_back('{17'h15555, 17'h0AAAA, 1'b0, none});
    rows.push_back('{17'h0AAAA, 17'h15555, 1'b0, none});
    rows.push_back('{17'd1, 17'd1, 1'b0, none});
    foreach (rows[i]) send_word(rows[i].u, rows[i].v, rows[i].known, rows[i].want);
    wait_idle();

    // Extreme components: most negative and most positive.
    write_span(REG_CORNER, {21'h100000, 21'h0FFFFF, 21'h100000});
    write_span(REG_HSPAN, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
    write_span(REG_VSPAN, {1'b1, 21'h100000, 21'h100000, 21'h100000});
    send_word(17'd0, 17'd0, 1'b0, none);
    send_word(17'h1FFFF, 17'h1FFFF, 1'b0, none);
    send_word(17'd65536, 17'd65536, 1'b0, none);
    wait_idle();

    // Sum cancels to exactly zero at one point: corner -1 x, hspan +2 x, u = 0.5.
    write_span(REG_CORNER, {21'd0, 21'd0, 21'h1FFC00});
    write_span(REG_HSPAN, {21'd0, 21'd0, 21'd2048});
    write_span(REG_VSPAN, '0);
    send_word(17'd32768, 17'd12345, 1'b1, zero_dir);
    send_word(17'd32769, 17'd0, 1'b0, none);
    send_word(17'd1, 17'd0, 1'b0, none);
    wait_idle();

    // Random phases, each with new spans.
    for (int ph = 0; ph < 12; ph++) begin
      write_span(REG_CORNER, rand_span());
      write_span(REG_HSPAN, rand_span());
      write_span(REG_VSPAN, rand_span());
      for (int k = 0; k < N_RANDOM / 12; k++) send_word(rand_uv(), rand_uv(), 1'b0, none);
      wait_idle();
    end

    if (err_cnt == 0 && dir_queue.size() == 0) begin
      $display("[camera_ray_direction] OK");
    end else begin
      $display("[camera_ray_direction] ERROR");
    end
    $finish;
  end

endmodule
